[src/gcd_pkg.sv]
package gcd_pkg;

  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [29:0] OCTANT_Q30 = 30'h2000_0000;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [22:0] RADIUS_M   = 23'd6378137;
  localparam logic [30:0] DIST_MAX   = 31'h7FFF_FFFF;

  // sine/cosine unit depth in cycles
  localparam int SC_LAT = 12;

  // reciprocals ceil(2^38 / k), exact floor division for values below 2^31
  localparam int RECIP_SHIFT = 38;
  localparam logic [35:0] SIN_RECIP [0:4] = '{
    36'd2498890064,   // 110
    36'd3817748708,   // 72
    36'd6544712071,   // 42
    36'd13743895348,  // 20
    36'd45812984491   // 6
  };
  localparam logic [35:0] COS_RECIP [0:3] = '{
    36'd3054198967,   // 90
    36'd4908534053,   // 56
    36'd9162596899,   // 30
    36'd22906492246   // 12
  };

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] a;
    logic [30:0] b;
    logic [1:0]  quad;
    logic        fold;
  } sc_stage_t;

  // Q30 product with rounding
  function automatic logic [30:0] mq(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(32'h2000_0000);
    return p[60:30];
  endfunction

  function automatic logic [30:0] recip_div(input logic [30:0] v, input logic [35:0] m);
    logic [66:0] p;
    p = 67'(v) * 67'(m);
    return 31'(p[66:RECIP_SHIFT]);
  endfunction

  function automatic logic [30:0] smag(input logic signed [31:0] v);
    logic [31:0] n;
    n = v[31] ? 32'(-v) : 32'(v);
    return n[30:0];
  endfunction

endpackage

[src/gcd_cdiv.sv]
module gcd_cdiv #(
  parameter int W  = 39,
  parameter int D  = 45,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  logic [W-1:0]  v_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [W-1:0]  q_o,
  output logic [PW-1:0] pay_o
);

  localparam int HW  = W - 24;
  localparam int SH  = HW + 7;
  localparam longint unsigned MH = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
  localparam longint unsigned ML = ((64'd1 << 38) + 64'(D) - 64'd1) / 64'(D);
  localparam int PHW = HW + SH + 1;
  localparam int RW  = HW + 7;

  logic [2:0]    vld;
  logic [PW-1:0] pay1, pay2;
  logic [HW-1:0] hi1, qh1, qh2;
  logic [23:0]   lo1;
  logic [30:0]   y2;

  logic [PHW-1:0] ph;
  logic [RW-1:0]  rem;
  logic [69:0]    pl;

  assign ph  = PHW'(v_i[W-1:24]) * PHW'(MH);
  assign rem = RW'(hi1) - RW'(qh1) * RW'(D);
  assign pl  = 70'(y2) * 70'(ML);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], vld_i};
    end
  end

  // high part first, then remainder joined to the low bits
  always_ff @(posedge clk) begin
    if (en) begin
      hi1   <= v_i[W-1:24];
      lo1   <= v_i[23:0];
      qh1   <= ph[SH +: HW];
      pay1  <= pay_i;
      qh2   <= qh1;
      y2    <= {rem[6:0], lo1};
      pay2  <= pay1;
      q_o   <= {qh2, pl[38 +: 24]};
      pay_o <= pay2;
    end
  end

  assign vld_o = vld[2];

endmodule

[src/gcd_sincos.sv]
module gcd_sincos #(
  parameter int PW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_i,
  input  logic [31:0]        phase_i,
  input  logic [PW-1:0]      pay_i,
  output logic               vld_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o,
  output logic [PW-1:0]      pay_o
);

  gcd_pkg::sc_stage_t st [0:gcd_pkg::SC_LAT-2];
  logic [gcd_pkg::SC_LAT-1:0] vld;
  logic [PW-1:0] pay [0:gcd_pkg::SC_LAT-2];

  logic [29:0] r0, rr0;
  logic        fold0;
  logic [61:0] xp0;
  logic [30:0] s0, c0, so, co;

  assign r0    = phase_i[29:0];
  assign fold0 = r0 > gcd_pkg::OCTANT_Q30;
  assign rr0   = fold0 ? 30'(gcd_pkg::ONE_Q30 - 31'(r0)) : r0;
  assign xp0   = 62'(rr0) * 62'(gcd_pkg::PI_Q30) + 62'(gcd_pkg::ONE_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[gcd_pkg::SC_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].x    <= xp0[60:31];
      st[0].x2   <= '0;
      st[0].a    <= '0;
      st[0].b    <= '0;
      st[0].quad <= phase_i[31:30];
      st[0].fold <= fold0;
      pay[0]     <= pay_i;
    end
  end

  for (genvar i = 1; i <= gcd_pkg::SC_LAT - 2; i++) begin : g_st
    logic [30:0] x2v;
    logic [30:0] am, bm;
    assign x2v = gcd_pkg::mq(31'(st[i-1].x), 31'(st[i-1].x));
    assign am  = gcd_pkg::mq(31'(st[i-1].x2), gcd_pkg::ONE_Q30 - st[i-1].a);
    assign bm  = gcd_pkg::mq(31'(st[i-1].x2), gcd_pkg::ONE_Q30 - st[i-1].b);
    if (i == 1) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          st[i]    <= st[i-1];
          st[i].x2 <= x2v[29:0];
          pay[i]   <= pay[i-1];
        end
      end
    end else if (i == 2) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          st[i]   <= st[i-1];
          st[i].a <= gcd_pkg::recip_div(31'(st[i-1].x2), gcd_pkg::SIN_RECIP[0]);
          st[i].b <= gcd_pkg::recip_div(31'(st[i-1].x2), gcd_pkg::COS_RECIP[0]);
          pay[i]  <= pay[i-1];
        end
      end
    end else if ((i % 2) == 1) begin : g_mul
      always_ff @(posedge clk) begin
        if (en) begin
          st[i]   <= st[i-1];
          st[i].a <= am;
          st[i].b <= bm;
          pay[i]  <= pay[i-1];
        end
      end
    end else if (i == gcd_pkg::SC_LAT - 2) begin : g_last
      // cosine closes with a halving
      always_ff @(posedge clk) begin
        if (en) begin
          st[i]   <= st[i-1];
          st[i].a <= gcd_pkg::recip_div(st[i-1].a, gcd_pkg::SIN_RECIP[(i-2)/2]);
          st[i].b <= st[i-1].b >> 1;
          pay[i]  <= pay[i-1];
        end
      end
    end else begin : g_div
      always_ff @(posedge clk) begin
        if (en) begin
          st[i]   <= st[i-1];
          st[i].a <= gcd_pkg::recip_div(st[i-1].a, gcd_pkg::SIN_RECIP[(i-2)/2]);
          st[i].b <= gcd_pkg::recip_div(st[i-1].b, gcd_pkg::COS_RECIP[(i-2)/2]);
          pay[i]  <= pay[i-1];
        end
      end
    end
  end

  localparam int LS = gcd_pkg::SC_LAT - 2;

  assign s0 = gcd_pkg::mq(31'(st[LS].x), gcd_pkg::ONE_Q30 - st[LS].a);
  assign c0 = gcd_pkg::ONE_Q30 - st[LS].b;
  assign so = st[LS].fold ? c0 : s0;
  assign co = st[LS].fold ? s0 : c0;

  always_ff @(posedge clk) begin
    if (en) begin
      pay_o <= pay[LS];
      unique case (st[LS].quad)
        2'd0: begin
          sin_o <= $signed(32'(so));
          cos_o <= $signed(32'(co));
        end
        2'd1: begin
          sin_o <= $signed(32'(co));
          cos_o <= -$signed(32'(so));
        end
        2'd2: begin
          sin_o <= -$signed(32'(so));
          cos_o <= -$signed(32'(co));
        end
        default: begin
          sin_o <= -$signed(32'(co));
          cos_o <= $signed(32'(so));
        end
      endcase
    end
  end

  assign vld_o = vld[gcd_pkg::SC_LAT-1];

endmodule

[src/gcd_sqrt_cell.sv]
module gcd_sqrt_cell #(
  parameter int IDX = 0,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  logic [60:0]   n_i,
  input  logic [60:0]   res_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [60:0]   n_o,
  output logic [60:0]   res_o,
  output logic [PW-1:0] pay_o
);

  localparam logic [60:0] BIT = 61'(1) << (60 - 2 * IDX);

  logic [61:0] sum;
  logic        ge;

  assign sum = {1'b0, res_i} + {1'b0, BIT};
  assign ge  = {1'b0, n_i} >= sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_o   <= ge ? n_i - sum[60:0] : n_i;
      res_o <= ge ? (res_i >> 1) + BIT : res_i >> 1;
      pay_o <= pay_i;
    end
  end

endmodule

[src/gcd_asin_cell.sv]
module gcd_asin_cell #(
  parameter int B  = 29,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  logic [30:0]   p_i,
  input  logic [30:0]   s_i,
  input  logic          big_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [30:0]   p_o,
  output logic [30:0]   s_o,
  output logic          big_o,
  output logic [PW-1:0] pay_o
);

  localparam int IW = PW + 63;

  logic [30:0]        cand;
  logic               sc_vld;
  logic signed [31:0] sv;
  logic [IW-1:0]      sc_pay;
  logic [30:0]        p_d, s_d;

  assign cand = p_i | (31'(1) << B);

  gcd_sincos #(.PW(IW)) u_sc (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_i  (vld_i),
    .phase_i(32'(cand)),
    .pay_i  ({pay_i, big_i, s_i, p_i}),
    .vld_o  (sc_vld),
    .sin_o  (sv),
    .cos_o  (),
    .pay_o  (sc_pay)
  );

  assign p_d = sc_pay[30:0];
  assign s_d = sc_pay[61:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= sc_vld;
    end
  end

  // keep the trial bit while its sine does not pass the target
  always_ff @(posedge clk) begin
    if (en) begin
      p_o   <= (sv <= $signed({1'b0, s_d})) ? (p_d | (31'(1) << B)) : p_d;
      s_o   <= s_d;
      big_o <= sc_pay[62];
      pay_o <= sc_pay[IW-1:63];
    end
  end

endmodule

[src/great_circle_distance_core.sv]
// Great-circle distance core, one point pair per transaction.
// Throughput: one transaction per cycle while the output skid stage is empty;
// the depth comes from the 30-cell arcsine chain, each cell running a 12-stage
// sine pipeline plus a compare.
// Reset (rst, synchronous) clears all valid bits and the output skid stage.
module great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int DIST_FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
  input  logic [0:0]   s_tuser,  // arg_missing
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // dist_km[30:0]
  output logic [0:0]   m_tuser   // is_null
);

  localparam int AW  = 62 - ANGLE_FRAC_BITS;
  localparam int DW  = AW - 3;
  localparam int SHA = 32 - ANGLE_FRAC_BITS;
  localparam int K   = 32 - DIST_FRAC_BITS;
  localparam int DWD = 23 + DIST_FRAC_BITS;

  logic en;

  // input stage
  logic               in_vld, in_null;
  logic signed [28:0] ang [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0]  <= $signed({s_tdata[27], s_tdata[27:0]});
      ang[1]  <= $signed(s_tdata[56:28]);
      ang[2]  <= $signed({s_tdata[84], s_tdata[84:57]});
      ang[3]  <= $signed(s_tdata[113:85]);
      in_null <= s_tuser[0];
    end
  end

  // degrees to turn phase: round(|deg| * 2^32 / 360), by a divide through 45
  logic [3:0]    neg;
  logic [DW-1:0] cq [0:3];
  logic          cd_vld;
  logic [4:0]    cd_pay;

  for (genvar l = 0; l < 4; l++) begin : g_ang
    logic [28:0]   mag;
    logic [AW-1:0] sum;
    assign neg[l] = ang[l][28];
    assign mag    = neg[l] ? 29'(-ang[l]) : 29'(ang[l]);
    assign sum    = (AW'(mag) << SHA) + AW'(180);
    if (l == 0) begin : g_lead
      gcd_cdiv #(.W(DW), .D(45), .PW(5)) u_div (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .vld_i(in_vld),
        .v_i  (sum[AW-1:3]),
        .pay_i({in_null, neg}),
        .vld_o(cd_vld),
        .q_o  (cq[l]),
        .pay_o(cd_pay)
      );
    end else begin : g_side
      gcd_cdiv #(.W(DW), .D(45), .PW(1)) u_div (
        .clk  (clk),
        .rst  (rst),
        .en   (en),
        .vld_i(in_vld),
        .v_i  (sum[AW-1:3]),
        .pay_i(1'b0),
        .vld_o(),
        .q_o  (cq[l]),
        .pay_o()
      );
    end
  end

  logic [31:0] phs [0:3];
  for (genvar l = 0; l < 4; l++) begin : g_phs
    assign phs[l] = cd_pay[l] ? 32'(-cq[l][31:0]) : cq[l][31:0];
  end

  logic        ph_vld, ph_null;
  logic [31:0] pa_lat, pb_lat, hd, hl;
  logic [31:0] dlat, dlon;

  assign dlat = phs[2] - phs[0];
  assign dlon = phs[3] - phs[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_vld <= 1'b0;
    end else if (en) begin
      ph_vld <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_lat  <= phs[0];
      pb_lat  <= phs[2];
      hd      <= dlat >> 1;
      hl      <= dlon >> 1;
      ph_null <= cd_pay[4];
    end
  end

  // trig of both latitudes and the two half differences
  logic               sc_vld, sc_null;
  logic signed [31:0] ca, cb, sd, sl;

  gcd_sincos #(.PW(1)) u_sc_a (
    .clk(clk), .rst(rst), .en(en), .vld_i(ph_vld), .phase_i(pa_lat), .pay_i(ph_null),
    .vld_o(sc_vld), .sin_o(), .cos_o(ca), .pay_o(sc_null)
  );
  gcd_sincos #(.PW(1)) u_sc_b (
    .clk(clk), .rst(rst), .en(en), .vld_i(ph_vld), .phase_i(pb_lat), .pay_i(1'b0),
    .vld_o(), .sin_o(), .cos_o(cb), .pay_o()
  );
  gcd_sincos #(.PW(1)) u_sc_d (
    .clk(clk), .rst(rst), .en(en), .vld_i(ph_vld), .phase_i(hd), .pay_i(1'b0),
    .vld_o(), .sin_o(sd), .cos_o(), .pay_o()
  );
  gcd_sincos #(.PW(1)) u_sc_l (
    .clk(clk), .rst(rst), .en(en), .vld_i(ph_vld), .phase_i(hl), .pay_i(1'b0),
    .vld_o(), .sin_o(sl), .cos_o(), .pay_o()
  );

  // haversine term h, clamped to [0, 1]
  logic        h1_vld, h2_vld, h3_vld;
  logic        h1_null, h2_null, h3_null;
  logic [30:0] m1, m3, ccm, m1b, m4;
  logic        ccs, m4s;
  logic [30:0] h3;
  logic signed [32:0] hs;

  assign hs = m4s ? $signed({2'b0, m1b}) - $signed({2'b0, m4})
                  : $signed({2'b0, m1b}) + $signed({2'b0, m4});

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld <= 1'b0;
      h2_vld <= 1'b0;
      h3_vld <= 1'b0;
    end else if (en) begin
      h1_vld <= sc_vld;
      h2_vld <= h1_vld;
      h3_vld <= h2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1      <= gcd_pkg::mq(gcd_pkg::smag(sd), gcd_pkg::smag(sd));
      m3      <= gcd_pkg::mq(gcd_pkg::smag(sl), gcd_pkg::smag(sl));
      ccm     <= gcd_pkg::mq(gcd_pkg::smag(ca), gcd_pkg::smag(cb));
      ccs     <= ca[31] ^ cb[31];
      h1_null <= sc_null;
      m4      <= gcd_pkg::mq(ccm, m3);
      m4s     <= ccs;
      m1b     <= m1;
      h2_null <= h1_null;
      h3_null <= h2_null;
      if (hs[32]) begin
        h3 <= '0;
      end else if (hs > $signed(33'(gcd_pkg::ONE_Q30))) begin
        h3 <= gcd_pkg::ONE_Q30;
      end else begin
        h3 <= hs[30:0];
      end
    end
  end

  // square root, one result bit per cell
  logic [60:0] sq_n   [0:31];
  logic [60:0] sq_res [0:31];
  logic        sq_vld [0:31];
  logic        sq_pay [0:31];

  assign sq_n[0]   = 61'(h3) << 30;
  assign sq_res[0] = '0;
  assign sq_vld[0] = h3_vld;
  assign sq_pay[0] = h3_null;

  for (genvar i = 0; i < 31; i++) begin : g_sqrt
    gcd_sqrt_cell #(.IDX(i), .PW(1)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vld_i(sq_vld[i]),
      .n_i  (sq_n[i]),
      .res_i(sq_res[i]),
      .pay_i(sq_pay[i]),
      .vld_o(sq_vld[i+1]),
      .n_o  (sq_n[i+1]),
      .res_o(sq_res[i+1]),
      .pay_o(sq_pay[i+1])
    );
  end

  // arcsine as a phase, one bit per cell from the top
  logic [30:0] as_p   [0:30];
  logic [30:0] as_s   [0:30];
  logic        as_big [0:30];
  logic        as_vld [0:30];
  logic        as_pay [0:30];

  assign as_p[0]   = '0;
  assign as_s[0]   = sq_res[31][30:0];
  assign as_big[0] = sq_res[31] >= 61'(gcd_pkg::ONE_Q30);
  assign as_vld[0] = sq_vld[31];
  assign as_pay[0] = sq_pay[31];

  for (genvar i = 0; i < 30; i++) begin : g_asin
    gcd_asin_cell #(.B(29 - i), .PW(1)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vld_i(as_vld[i]),
      .p_i  (as_p[i]),
      .s_i  (as_s[i]),
      .big_i(as_big[i]),
      .pay_i(as_pay[i]),
      .vld_o(as_vld[i+1]),
      .p_o  (as_p[i+1]),
      .s_o  (as_s[i+1]),
      .big_o(as_big[i+1]),
      .pay_o(as_pay[i+1])
    );
  end

  // angle to radians * 2^32, then times the radius
  logic        f1_vld, f2_vld, f1_null, f2_null;
  logic [30:0] pf;
  logic [62:0] tp;
  logic [34:0] tr;
  logic [57:0] prod, prnd;

  assign pf   = as_big[30] ? gcd_pkg::ONE_Q30 : as_p[30];
  assign tp   = 63'(pf) * 63'(gcd_pkg::PI_Q30) + 63'(32'h0800_0000);
  assign prnd = prod + (58'(500) << K);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= as_vld[30];
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr      <= tp[62:28];
      f1_null <= as_pay[30];
      prod    <= 58'(tr) * 58'(gcd_pkg::RADIUS_M);
      f2_null <= f1_null;
    end
  end

  logic           dd_vld, dd_null;
  logic [DWD-1:0] dq;

  gcd_cdiv #(.W(DWD), .D(125), .PW(1)) u_ddiv (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vld_i(f2_vld),
    .v_i  (prnd[K+3 +: DWD]),
    .pay_i(f2_null),
    .vld_o(dd_vld),
    .q_o  (dq),
    .pay_o(dd_null)
  );

  // output register and skid stage
  logic        p_vld, p_null, sk_vld, sk_null;
  logic [30:0] p_dist, sk_dist;

  assign en = !sk_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld  <= 1'b0;
      sk_vld <= 1'b0;
    end else begin
      if (en) begin
        p_vld <= dd_vld;
      end
      if (sk_vld) begin
        if (m_tready) begin
          sk_vld <= 1'b0;
        end
      end else if (p_vld && !m_tready) begin
        sk_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_null <= dd_null;
      if (dd_null) begin
        p_dist <= '0;
      end else if (dq > DWD'(gcd_pkg::DIST_MAX)) begin
        p_dist <= gcd_pkg::DIST_MAX;
      end else begin
        p_dist <= dq[30:0];
      end
    end
    if (!sk_vld) begin
      sk_dist <= p_dist;
      sk_null <= p_null;
    end
  end

  assign s_tready   = en;
  assign m_tvalid   = sk_vld | p_vld;
  assign m_tdata    = {1'b0, sk_vld ? sk_dist : p_dist};
  assign m_tuser[0] = sk_vld ? sk_null : p_null;

endmodule

[src/gcd_checker.sv]
module gcd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [119:0] s_tdata,
  input logic [0:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("null result with nonzero distance");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_top_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("padding bit set in output data");

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

[tb/great_circle_distance_core_test.sv]
module great_circle_distance_core_test;

  localparam int ANG_FB       = 20;
  localparam int DIST_FB      = 16;
  localparam int LAT_MAX      = 94371840;
  localparam int LON_MAX      = 188743680;
  localparam int CORE_LATENCY = 447;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint unsigned Q30   = 64'd1 << 30;
  localparam longint unsigned PI_FX = 64'd3373259426;

  typedef struct packed {
    logic [30:0] dist_km;
    logic        is_null;
  } distance_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
  logic [0:0]   s_tuser;  // arg_missing
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;  // dist_km[30:0]
  logic [0:0]   m_tuser;  // is_null

  distance_t expected_dist[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        sender_idle_on = 1'b1;
  bit        receiver_idle_on = 1'b1;
  int        hold_request = 0;

  great_circle_distance_core #(
    .ANGLE_FRAC_BITS(ANG_FB),
    .DIST_FRAC_BITS(DIST_FB)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic logic [31:0] angle_phase(input longint v);
    longint unsigned mag, den;
    logic [31:0] p;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    den = 64'd360 << ANG_FB;
    p = 32'(((mag << 32) + den / 2) / den);
    return (v < 0) ? 32'(-p) : p;
  endfunction

  function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint sqmul(input longint a, input longint b);
    longint unsigned m;
    m = qmul((a < 0) ? -a : a, (b < 0) ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void octant_trig(input longint unsigned r,
                                      output longint unsigned s, output longint unsigned c);
    longint unsigned x, x2, t, u;
    x  = (r * PI_FX + Q30) >> 31;
    x2 = qmul(x, x);
    t = Q30 - x2 / 110;
    t = Q30 - qmul(x2, t) / 72;
    t = Q30 - qmul(x2, t) / 42;
    t = Q30 - qmul(x2, t) / 20;
    t = Q30 - qmul(x2, t) / 6;
    s = qmul(x, t);
    u = Q30 - x2 / 90;
    u = Q30 - qmul(x2, u) / 56;
    u = Q30 - qmul(x2, u) / 30;
    u = Q30 - qmul(x2, u) / 12;
    u = Q30 - qmul(x2, u) / 2;
    c = u;
  endfunction

  function automatic void phase_trig(input logic [31:0] p, output longint s, output longint c);
    longint unsigned r, s0, c0;
    r = {34'd0, p[29:0]};
    // upper half of a quadrant: evaluate the complement and swap
    if (r > (64'd1 << 29)) octant_trig(Q30 - r, c0, s0);
    else octant_trig(r, s0, c0);
    case (p[31:30])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned arcsine_phase(input longint unsigned s);
    logic [31:0] p, cand;
    longint sv, cv;
    if (s >= Q30) return Q30;
    p = 0;
    for (int b = 29; b >= 0; b--) begin
      cand = p | (32'd1 << b);
      phase_trig(cand, sv, cv);
      if (sv <= longint'(s)) p = cand;
    end
    return {32'd0, p};
  endfunction

  function automatic distance_t predict_distance(input logic [119:0] pair, input logic missing);
    distance_t res;
    logic [31:0] pa_lat, pa_lon, pb_lat, pb_lon, dlat, dlon;
    longint sa, ca, sb, cb, sd, sl, unused, h;
    longint unsigned p, t, den, d;
    if (missing) begin
      res.dist_km = '0;
      res.is_null = 1'b1;
      return res;
    end
    pa_lat = angle_phase(longint'(signed'(pair[27:0])));
    pa_lon = angle_phase(longint'(signed'(pair[56:28])));
    pb_lat = angle_phase(longint'(signed'(pair[84:57])));
    pb_lon = angle_phase(longint'(signed'(pair[113:85])));
    dlat = pb_lat - pa_lat;
    dlon = pb_lon - pa_lon;
    phase_trig(pa_lat, sa, ca);
    phase_trig(pb_lat, sb, cb);
    phase_trig(dlat >> 1, sd, unused);
    phase_trig(dlon >> 1, sl, unused);
    h = sqmul(sd, sd) + sqmul(sqmul(ca, cb), sqmul(sl, sl));
    if (h < 0) h = 0;
    if (h > longint'(Q30)) h = Q30;
    p = arcsine_phase(int_sqrt(longint'(h) << 30));
    t = (p * PI_FX + (64'd1 << 27)) >> 28;
    den = 64'd1000 << (32 - DIST_FB);
    d = (t * 64'd6378137 + den / 2) / den;
    if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
    res.dist_km = d[30:0];
    res.is_null = 1'b0;
    return res;
  endfunction

  // ---------------- driving ----------------

  task automatic send_pair(input logic [27:0] lat_a, input logic [28:0] lon_a,
                           input logic [27:0] lat_b, input logic [28:0] lon_b,
                           input logic missing);
    int gap;
    logic [119:0] pair;
    gap = sender_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair = {6'd0, lon_b, lat_b, lon_a, lat_a};
    s_tvalid <= 1'b1;
    s_tdata  <= pair;
    s_tuser  <= missing;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    expected_dist.push_back(predict_distance(pair, missing));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int w;
    forever begin
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      w = receiver_idle_on ? $urandom_range(0, 11) : 0;
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid && hold_request == 0) @(negedge clk);
      @(posedge clk);
    end
  end

  // outputs are stable at the falling edge; a transaction there completes at the next rise
  always @(negedge clk) begin
    distance_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dist.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[30:0], 0);
      end else begin
        want = expected_dist.pop_front();
        if (m_tdata[30:0] !== want.dist_km)
          report_mismatch("dist_km", m_tdata[30:0], want.dist_km);
        if (m_tdata[31] !== 1'b0) report_mismatch("tdata pad", m_tdata[31], 0);
        if (m_tuser[0] !== want.is_null)
          report_mismatch("is_null", m_tuser[0], want.is_null);
      end
    end
  end

  // ---------------- tests ----------------

  function automatic logic [27:0] rand_lat();
    if ($urandom_range(0, 19) == 0) return 28'($urandom);
    return 28'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic [28:0] rand_lon();
    if ($urandom_range(0, 19) == 0) return 29'($urandom);
    return 29'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
  endfunction

  task automatic test_directed();
    send_pair(0, 0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);                 // pole to pole
    send_pair(0, 0, 0, LON_MAX, 0);                        // half way round the equator
    send_pair(0, -LON_MAX, 0, LON_MAX, 0);                 // same meridian, wrapped
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0);
    send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 2, -LON_MAX * 2 / 3, 0); // antipodes
    send_pair(12345678, 23456789, 12345678, 23456789, 0);  // identical points
    send_pair(12345678, 23456789, 12345679, 23456790, 0);  // very short hop
    send_pair(28'h7FF_FFFF, 29'h0FFF_FFFF, 28'h800_0000, 29'h1000_0000, 0); // out of range
    send_pair(28'h800_0000, 29'h1000_0000, 28'h7FF_FFFF, 29'h0FFF_FFFF, 0);
    send_pair(28'hFFF_FFFF, 29'h1FFF_FFFF, 1, 1, 0);
    send_pair(28'hFFF_FFFF, 29'h1FFF_FFFF, 28'hFFF_FFFF, 29'h1FFF_FFFF, 1); // null, junk
    send_pair(0, 0, LAT_MAX, LON_MAX, 1);
    send_pair(0, 0, 0, 0, 1);
    send_pair(LAT_MAX, LON_MAX / 2, LAT_MAX, -LON_MAX / 2, 0);
  endtask

  task automatic test_random(input int count);
    logic [27:0] la;
    logic [28:0] lo;
    for (int i = 0; i < count; i++) begin
      la = rand_lat();
      lo = rand_lon();
      if (i % 50 == 0) begin
        sender_idle_on = ($urandom_range(0, 2) != 0);
        receiver_idle_on = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 3))
        0: send_pair(la, lo, 28'(la + $urandom_range(0, 2000) - 1000),
                     29'(lo + $urandom_range(0, 2000) - 1000), $urandom_range(0, 9) == 0);
        1: send_pair(la, lo, 28'(-la), 29'(lo + LON_MAX), $urandom_range(0, 9) == 0);
        default: send_pair(la, lo, rand_lat(), rand_lon(), $urandom_range(0, 9) == 0);
      endcase
    end
  endtask

  // receiver stops for well past the pipeline depth while items keep coming
  task automatic test_backpressure();
    sender_idle_on = 1'b0;
    hold_request = 3 * CORE_LATENCY;
    for (int i = 0; i < CORE_LATENCY + 100; i++)
      send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon(), $urandom_range(0, 9) == 0);
    sender_idle_on = 1'b1;
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(300);
    s_tvalid <= 1'b0;
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (CORE_LATENCY + 50) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
